@@ hdl/csvtok_pkg.sv @@
// Shared types, byte codes and command codes of the CSV field tokenizer.
package csvtok_pkg;

    localparam int BYTE_W        = 8;
    localparam int COL_OUT_W     = 10;
    localparam int M_TDATA_W     = 24;
    localparam int M_TUSER_W     = 3;

    localparam int PEND_DEPTH_DEF = 16;
    localparam int MAX_COLS_DEF   = 1024;

    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP       = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;

    typedef logic [3:0] op_t;

    localparam op_t OP_NOP     = 4'd0;  // no beat taken
    localparam op_t OP_DROP    = 4'd1;  // take the beat, no effect on the datapath
    localparam op_t OP_CONTENT = 4'd2;  // content byte with nothing held ahead of it, or a whitespace byte
    localparam op_t OP_HOLD    = 4'd3;  // content byte behind held whitespace
    localparam op_t OP_FIELD   = 4'd4;  // field end
    localparam op_t OP_ROW     = 4'd5;  // field end with row end
    localparam op_t OP_EOD_ROW = 4'd6;  // row end only (end of data after a delimiter)
    localparam op_t OP_POP     = 4'd7;  // send the oldest held whitespace byte
    localparam op_t OP_FINAL   = 4'd8;  // send the held content byte

    typedef struct packed {
        logic out_free;
        logic is_delim;
        logic is_quote;
        logic is_cr;
        logic is_lf;
        logic is_ws;
        logic pend_any;
        logic col_any;
    } stat_t;

endpackage

@@ hdl/csv_field_tokenizer.sv @@
// Top level of the CSV field tokenizer: stream ports, delimiter register port.
// Latency: a result beat is valid the cycle after the byte is taken; behind held
// blanks the held blanks go out first, oldest first, and then the byte itself.
// Throughput: one byte per cycle while the result register drains; a content byte
// behind held blanks stalls the input until the blanks and the byte are passed on.
// Reset (rst_n, async, active low): delimiter back to comma, parser at row start.
module csv_field_tokenizer
#(
    parameter int PEND_DEPTH = csvtok_pkg::PEND_DEPTH_DEF,
    parameter int MAX_COLS   = csvtok_pkg::MAX_COLS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // delimiter register write
    input  logic                                cfg_we,
    input  logic [csvtok_pkg::BYTE_W-1:0]       cfg_wdata,
    // input text beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [csvtok_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] end_of_data
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csvtok_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] byte_value,
                                                           // [17:8] column,
                                                           // [18] trim_overflow, zero pad
    output logic [csvtok_pkg::M_TUSER_W-1:0]    m_tuser,   // [0] has_byte, [1] field_end,
                                                           // [2] row_end
    output logic                                m_tlast    // last beat caused by one input
);

    csvtok_pkg::stat_t  stat;
    csvtok_pkg::op_t    op;

    // The controller tracks the quoting mode, the CR of a CR LF pair and the
    // whitespace flush; it issues one command per cycle to the datapath.
    csvtok_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .eod      (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    // The datapath classifies the incoming byte, holds inner whitespace until
    // the next content byte, counts columns and owns the result register.
    csvtok_dp
    #(
        .PEND_DEPTH (PEND_DEPTH),
        .MAX_COLS   (MAX_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .op        (op),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ hdl/csvtok_ctrl.sv @@
// Parse and sequencing state machine of the CSV field tokenizer.
module csvtok_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                eod,
    output logic                s_tready,
    input  csvtok_pkg::stat_t   stat,
    output csvtok_pkg::op_t     op
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_UNQ    = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_QSEEN  = 3'd3;
    localparam logic [2:0] MODE_AFTER  = 3'd4;

    logic                state_reg;
    logic                state_next;
    logic [2:0]          mode_reg;
    logic [2:0]          mode_next;
    logic                cr_reg;
    logic                cr_next;
    logic                sep_hit;
    csvtok_pkg::op_t     sep_op;
    csvtok_pkg::op_t     content_op;

    assign sep_hit    = stat.is_delim || stat.is_cr || stat.is_lf;
    assign sep_op     = stat.is_delim ? csvtok_pkg::OP_FIELD : csvtok_pkg::OP_ROW;
    assign content_op = (!stat.is_ws && stat.pend_any) ? csvtok_pkg::OP_HOLD
                                                        : csvtok_pkg::OP_CONTENT;
    assign s_tready   = (state_reg == ST_IDLE) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cr_next    = cr_reg;
        op         = csvtok_pkg::OP_NOP;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cr_next = 1'b0;
                    if (eod)
                    begin
                        if (mode_reg != MODE_START)
                        begin
                            op        = csvtok_pkg::OP_ROW;
                            mode_next = MODE_START;
                        end
                        else if (stat.col_any)
                        begin
                            op = csvtok_pkg::OP_EOD_ROW;
                        end
                        else
                        begin
                            op = csvtok_pkg::OP_DROP;
                        end
                    end
                    else if (cr_reg && stat.is_lf)
                    begin
                        // swallow the LF of a CR LF pair
                        op = csvtok_pkg::OP_DROP;
                    end
                    else
                    begin
                        unique case (mode_reg)
                            MODE_UNQ:
                            begin
                                if (sep_hit)
                                begin
                                    op        = sep_op;
                                    mode_next = MODE_START;
                                    cr_next   = !stat.is_delim && stat.is_cr;
                                end
                                else
                                begin
                                    op = content_op;
                                end
                            end
                            MODE_QUOTED:
                            begin
                                if (stat.is_quote)
                                begin
                                    op        = csvtok_pkg::OP_DROP;
                                    mode_next = MODE_QSEEN;
                                end
                                else
                                begin
                                    op = content_op;
                                end
                            end
                            MODE_QSEEN:
                            begin
                                if (stat.is_quote)
                                begin
                                    // doubled quote: one literal quote
                                    op        = content_op;
                                    mode_next = MODE_QUOTED;
                                end
                                else if (sep_hit)
                                begin
                                    op        = sep_op;
                                    mode_next = MODE_START;
                                    cr_next   = !stat.is_delim && stat.is_cr;
                                end
                                else
                                begin
                                    op        = csvtok_pkg::OP_DROP;
                                    mode_next = MODE_AFTER;
                                end
                            end
                            MODE_AFTER:
                            begin
                                if (sep_hit)
                                begin
                                    op        = sep_op;
                                    mode_next = MODE_START;
                                    cr_next   = !stat.is_delim && stat.is_cr;
                                end
                                else
                                begin
                                    op = csvtok_pkg::OP_DROP;
                                end
                            end
                            default:
                            begin
                                // field start
                                if (stat.is_quote)
                                begin
                                    op        = csvtok_pkg::OP_DROP;
                                    mode_next = MODE_QUOTED;
                                end
                                else if (sep_hit)
                                begin
                                    op        = sep_op;
                                    mode_next = MODE_START;
                                    cr_next   = !stat.is_delim && stat.is_cr;
                                end
                                else
                                begin
                                    op        = content_op;
                                    mode_next = MODE_UNQ;
                                end
                            end
                        endcase
                    end
                    if (op == csvtok_pkg::OP_HOLD)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    if (stat.pend_any)
                    begin
                        op = csvtok_pkg::OP_POP;
                    end
                    else
                    begin
                        op         = csvtok_pkg::OP_FINAL;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_START;
            cr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cr_reg    <= cr_next;
        end
    end

endmodule

@@ hdl/csvtok_dp.sv @@
// Datapath of the CSV field tokenizer: delimiter, whitespace store, column and result register.
module csvtok_dp
#(
    parameter int PEND_DEPTH = csvtok_pkg::PEND_DEPTH_DEF,
    parameter int MAX_COLS   = csvtok_pkg::MAX_COLS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csvtok_pkg::BYTE_W-1:0]       cfg_wdata,
    input  logic [csvtok_pkg::BYTE_W-1:0]       in_byte,
    input  csvtok_pkg::op_t                     op,
    output csvtok_pkg::stat_t                   stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csvtok_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [csvtok_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                                m_tlast
);

    localparam int CNT_W  = $clog2(PEND_DEPTH + 1);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int PAD_W  = csvtok_pkg::M_TDATA_W - csvtok_pkg::BYTE_W
                            - csvtok_pkg::COL_OUT_W - 1;
    localparam logic [COL_W-1:0] COL_TOP  = COL_W'(MAX_COLS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PEND_DEPTH);

    logic [csvtok_pkg::BYTE_W-1:0]      delim_reg;
    logic [csvtok_pkg::BYTE_W-1:0]      delim_next;
    logic                               content_reg;
    logic                               content_next;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic [PEND_DEPTH-1:0]              kinds_reg;
    logic [PEND_DEPTH-1:0]              kinds_next;
    logic [COL_W-1:0]                   col_reg;
    logic [COL_W-1:0]                   col_next;
    logic                               ovf_reg;
    logic                               ovf_next;
    logic [csvtok_pkg::BYTE_W-1:0]      hold_reg;
    logic [csvtok_pkg::BYTE_W-1:0]      hold_next;
    logic                               m_valid_reg;
    logic                               m_valid_next;

    logic                               has_reg;
    logic [csvtok_pkg::BYTE_W-1:0]      byte_reg;
    logic                               fe_reg;
    logic                               re_reg;
    logic [csvtok_pkg::COL_OUT_W-1:0]   colout_reg;
    logic                               ovfout_reg;
    logic                               last_reg;

    logic                               emit;
    logic                               e_has;
    logic [csvtok_pkg::BYTE_W-1:0]      e_byte;
    logic                               e_fe;
    logic                               e_re;
    logic                               e_last;
    logic                               is_tab;
    logic [COL_W+csvtok_pkg::COL_OUT_W-1:0] col_ext;

    assign is_tab  = (in_byte == csvtok_pkg::CH_TAB);
    assign col_ext = {{csvtok_pkg::COL_OUT_W{1'b0}}, col_reg};

    assign stat.out_free     = !m_valid_reg || m_tready;
    assign stat.is_delim     = (in_byte == delim_reg);
    assign stat.is_quote     = (in_byte == csvtok_pkg::CH_QUOTE);
    assign stat.is_cr        = (in_byte == csvtok_pkg::CH_CR);
    assign stat.is_lf        = (in_byte == csvtok_pkg::CH_LF);
    assign stat.is_ws        = (in_byte == csvtok_pkg::CH_SP) || is_tab;
    assign stat.pend_any     = (count_reg != '0);
    assign stat.col_any      = (col_reg != '0);

    always_comb
    begin
        delim_next   = cfg_we ? cfg_wdata : delim_reg;
        content_next = content_reg;
        count_next   = count_reg;
        kinds_next   = kinds_reg;
        col_next     = col_reg;
        ovf_next     = ovf_reg;
        hold_next    = hold_reg;
        emit         = 1'b0;
        e_has        = 1'b0;
        e_byte       = '0;
        e_fe         = 1'b0;
        e_re         = 1'b0;
        e_last       = 1'b1;
        unique case (op) inside
            csvtok_pkg::OP_NOP, csvtok_pkg::OP_DROP:
            begin
            end
            csvtok_pkg::OP_CONTENT:
            begin
                if (stat.is_ws)
                begin
                    // leading whitespace is dropped, inner whitespace is held
                    if (content_reg)
                    begin
                        if (count_reg < CNT_FULL)
                        begin
                            for (int i = 0; i < PEND_DEPTH; i++)
                            begin
                                if (count_reg == CNT_W'(i))
                                begin
                                    kinds_next[i] = is_tab;
                                end
                            end
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    emit         = 1'b1;
                    e_has        = 1'b1;
                    e_byte       = in_byte;
                    content_next = 1'b1;
                    count_next   = '0;
                end
            end
            csvtok_pkg::OP_HOLD:
            begin
                hold_next = in_byte;
            end
            csvtok_pkg::OP_FIELD, csvtok_pkg::OP_ROW:
            begin
                emit = 1'b1;
                e_fe = 1'b1;
                e_re = (op == csvtok_pkg::OP_ROW);
                if (op == csvtok_pkg::OP_ROW)
                begin
                    col_next = '0;
                end
                else if (col_reg < COL_TOP)
                begin
                    col_next = col_reg + COL_W'(1);
                end
                content_next = 1'b0;
                count_next   = '0;
            end
            csvtok_pkg::OP_EOD_ROW:
            begin
                emit         = 1'b1;
                e_re         = 1'b1;
                col_next     = '0;
                content_next = 1'b0;
                count_next   = '0;
            end
            csvtok_pkg::OP_POP:
            begin
                emit       = 1'b1;
                e_has      = 1'b1;
                e_byte     = kinds_reg[0] ? csvtok_pkg::CH_TAB : csvtok_pkg::CH_SP;
                e_last     = 1'b0;
                kinds_next = kinds_reg >> 1;
                count_next = count_reg - CNT_W'(1);
            end
            csvtok_pkg::OP_FINAL:
            begin
                emit         = 1'b1;
                e_has        = 1'b1;
                e_byte       = hold_reg;
                content_next = 1'b1;
                count_next   = '0;
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg   <= csvtok_pkg::DELIM_RESET;
            content_reg <= 1'b0;
            count_reg   <= '0;
            col_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            delim_reg   <= delim_next;
            content_reg <= content_next;
            count_reg   <= count_next;
            col_reg     <= col_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        kinds_reg <= kinds_next;
        hold_reg  <= hold_next;
        if (emit)
        begin
            has_reg    <= e_has;
            byte_reg   <= e_byte;
            fe_reg     <= e_fe;
            re_reg     <= e_re;
            colout_reg <= col_ext[csvtok_pkg::COL_OUT_W-1:0];
            ovfout_reg <= ovf_reg;
            last_reg   <= e_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, ovfout_reg, colout_reg, byte_reg};
    assign m_tuser  = {re_reg, fe_reg, has_reg};
    assign m_tlast  = last_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking stream testbench for the CSV field tokenizer.
module tb;

    localparam int BYTE_W      = csvtok_pkg::BYTE_W;
    localparam int COL_OUT_W   = csvtok_pkg::COL_OUT_W;
    localparam int M_TDATA_W   = csvtok_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = csvtok_pkg::M_TUSER_W;
    localparam int HALF_PERIOD = 6;
    localparam int RST_CYCLES  = 5;
    localparam int PEND        = csvtok_pkg::PEND_DEPTH_DEF;
    localparam int COL_TOP     = csvtok_pkg::MAX_COLS_DEF - 1;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int SETTLE      = 8;      // cycles to let a no-result beat clear the block
    localparam int MAX_PRINTS  = 40;
    localparam int HOLD_CYCLES = 400;    // long receiver hold-off, fills the block

    typedef enum logic [2:0] {PM_START, PM_UNQ, PM_QUOTED, PM_QSEEN, PM_AFTER} pmode_t;

    // one beat of CSV text
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eod;
    } text_t;

    // one token beat on the master side
    typedef struct packed {
        logic                 has_byte;
        logic [BYTE_W-1:0]    value;
        logic                 fe;
        logic                 re;
        logic [COL_OUT_W-1:0] col;
        logic                 ovf;
        logic                 is_last;
    } token_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [BYTE_W-1:0]    cfg_wdata = csvtok_pkg::DELIM_RESET;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] data_byte
    logic                 s_tuser   = 1'b0; // [0] end_of_data
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [7:0] byte_value, [17:8] column, [18] trim_overflow
    logic [M_TUSER_W-1:0] m_tuser;          // [0] has_byte, [1] field_end, [2] row_end
    logic                 m_tlast;

    csv_field_tokenizer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Tokenizer state as the testbench tracks it
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] delim_reg = csvtok_pkg::DELIM_RESET;
    pmode_t            pmode     = PM_START;
    bit                content_seen;
    int                pend_cnt;
    bit                pend_tab [PEND];
    int                col_idx;
    bit                cr_seen;
    bit                ovf_seen;

    // token built last in this step; tlast goes on it once the step is done
    token_t held;
    bit     have_held;

    text_t  text_q  [$];   // text beats waiting for the driver
    token_t token_q [$];   // tokens the block still owes

    int n_text;
    int beats_in;
    int results_seen;
    int errors;
    int n_settings;
    int cycles;

    int src_gap;
    int src_calm;
    int snk_gap;
    int snk_calm;
    bit hold_arm;
    bit hold_done;
    int hold_left;

    text_t drv_item;

    function automatic void emit_token(logic has, logic [BYTE_W-1:0] val, logic fe, logic re);
        if (have_held)
            token_q.push_back(held);
        held.has_byte = has;
        held.value    = has ? val : '0;
        held.fe       = fe;
        held.re       = re;
        held.col      = COL_OUT_W'(col_idx);
        held.ovf      = ovf_seen;
        held.is_last  = 1'b0;
        have_held     = 1'b1;
    endfunction

    // Content byte of the field: drop leading blanks, hold inner ones, flush them ahead of the next real byte.
    function automatic void add_content(logic [BYTE_W-1:0] b);
        if (b == csvtok_pkg::CH_SP || b == csvtok_pkg::CH_TAB)
        begin
            if (!content_seen)
                return;
            if (pend_cnt < PEND)
            begin
                pend_tab[pend_cnt] = (b == csvtok_pkg::CH_TAB);
                pend_cnt++;
            end
            else
                ovf_seen = 1'b1;
            return;
        end
        for (int i = 0; i < pend_cnt; i++)
            emit_token(1'b1, pend_tab[i] ? csvtok_pkg::CH_TAB : csvtok_pkg::CH_SP, 1'b0, 1'b0);
        pend_cnt     = 0;
        content_seen = 1'b1;
        emit_token(1'b1, b, 1'b0, 1'b0);
    endfunction

    function automatic void close_field(logic row);
        emit_token(1'b0, '0, 1'b1, row);
        if (row)
            col_idx = 0;
        else if (col_idx < COL_TOP)
            col_idx++;
        pmode        = PM_START;
        content_seen = 1'b0;
        pend_cnt     = 0;
    endfunction

    // Delimiter or line end outside quotes; the delimiter test wins.
    function automatic bit split_on(logic [BYTE_W-1:0] b);
        if (b == delim_reg)
        begin
            close_field(1'b0);
            return 1'b1;
        end
        if (b == csvtok_pkg::CH_CR || b == csvtok_pkg::CH_LF)
        begin
            close_field(1'b1);
            cr_seen = (b == csvtok_pkg::CH_CR);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the tokens one accepted text beat causes.
    function automatic void tokenize_byte(text_t it);
        have_held = 1'b0;
        if (it.eod)
        begin
            cr_seen = 1'b0;
            if (pmode != PM_START)
                close_field(1'b1);
            else if (col_idx != 0)
            begin
                // trailing delimiter: row end only, no empty field
                emit_token(1'b0, '0, 1'b0, 1'b1);
                col_idx      = 0;
                content_seen = 1'b0;
                pend_cnt     = 0;
            end
        end
        else if (cr_seen && it.data == csvtok_pkg::CH_LF)
            cr_seen = 1'b0;   // swallow the LF of CR LF
        else
        begin
            cr_seen = 1'b0;
            case (pmode)
                PM_UNQ:
                begin
                    if (!split_on(it.data))
                        add_content(it.data);
                end
                PM_QUOTED:
                begin
                    if (it.data == csvtok_pkg::CH_QUOTE)
                        pmode = PM_QSEEN;
                    else
                        add_content(it.data);
                end
                PM_QSEEN:
                begin
                    if (it.data == csvtok_pkg::CH_QUOTE)
                    begin
                        pmode = PM_QUOTED;
                        add_content(csvtok_pkg::CH_QUOTE);
                    end
                    else
                    begin
                        pmode = PM_AFTER;
                        void'(split_on(it.data));
                    end
                end
                PM_AFTER:
                    void'(split_on(it.data));
                default:
                begin
                    if (it.data == csvtok_pkg::CH_QUOTE)
                        pmode = PM_QUOTED;
                    else if (!split_on(it.data))
                    begin
                        pmode = PM_UNQ;
                        add_content(it.data);
                    end
                end
            endcase
        end
        if (have_held)
        begin
            held.is_last = 1'b1;
            token_q.push_back(held);
            have_held = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void push_text(logic [BYTE_W-1:0] b, logic eod);
        text_q.push_back(text_t'({b, eod}));
        n_text++;
    endfunction

    // end-of-data beat; the data byte is don't-care, so randomize it
    function automatic void push_eod();
        push_text(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            push_text(s[i], 1'b0);
    endfunction

    function automatic bit is_special(logic [BYTE_W-1:0] b);
        return b == delim_reg || b == csvtok_pkg::CH_QUOTE || b == csvtok_pkg::CH_CR ||
               b == csvtok_pkg::CH_LF || b == csvtok_pkg::CH_SP || b == csvtok_pkg::CH_TAB;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_plain();
        logic [BYTE_W-1:0] b;
        do
            b = ($urandom_range(0, 99) < 80) ? BYTE_W'($urandom_range(33, 126))
                                             : BYTE_W'($urandom_range(0, 255));
        while (is_special(b));
        return b;
    endfunction

    function automatic void push_ws_run(int max_len);
        repeat ($urandom_range(1, max_len))
            push_text($urandom_range(0, 1) ? csvtok_pkg::CH_TAB : csvtok_pkg::CH_SP, 1'b0);
    endfunction

    function automatic void gen_field(int ws_max);
        int kind;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            // empty field, sometimes blanks only
            if ($urandom_range(0, 3) == 0)
                push_ws_run(3);
            return;
        end
        if (kind < 45)
        begin
            push_text(csvtok_pkg::CH_QUOTE, 1'b0);
            repeat ($urandom_range(0, 6))
            begin
                k = $urandom_range(0, 9);
                if (k < 5)
                    push_text(pick_plain(), 1'b0);
                else if (k < 7)
                begin
                    push_text(csvtok_pkg::CH_QUOTE, 1'b0);
                    push_text(csvtok_pkg::CH_QUOTE, 1'b0);
                end
                else if (k < 8)
                    push_ws_run(ws_max);
                else
                begin
                    // separators inside quotes are content
                    case ($urandom_range(0, 2))
                        0:       push_text(delim_reg, 1'b0);
                        1:       push_text(csvtok_pkg::CH_CR, 1'b0);
                        default: push_text(csvtok_pkg::CH_LF, 1'b0);
                    endcase
                end
            end
            push_text(csvtok_pkg::CH_QUOTE, 1'b0);
            // junk after the closing quote, dropped up to the separator
            if ($urandom_range(0, 4) == 0)
            begin
                push_text(pick_plain(), 1'b0);
                repeat ($urandom_range(0, 2))
                    push_text($urandom_range(0, 1) ? csvtok_pkg::CH_QUOTE : pick_plain(),
                              1'b0);
            end
            return;
        end
        if ($urandom_range(0, 2) == 0)
            push_ws_run(3);
        push_text(pick_plain(), 1'b0);
        repeat ($urandom_range(0, 5))
        begin
            if ($urandom_range(0, 3) == 0)
                push_ws_run(ws_max);
            push_text(($urandom_range(0, 9) == 0) ? csvtok_pkg::CH_QUOTE : pick_plain(), 1'b0);
        end
        if ($urandom_range(0, 2) == 0)
            push_ws_run(3);
    endfunction

    function automatic void gen_row(int ws_max);
        int ncols;
        int r;
        // noise: raw bytes and stray end-of-data beats
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    push_eod();
                else
                    push_text(BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
        end
        ncols = $urandom_range(1, 5);
        for (int c = 0; c < ncols; c++)
        begin
            gen_field(ws_max);
            if (c < ncols - 1)
                push_text(delim_reg, 1'b0);
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            push_text(csvtok_pkg::CH_LF, 1'b0);
        else if (r < 65)
            push_text(csvtok_pkg::CH_CR, 1'b0);
        else if (r < 85)
        begin
            push_text(csvtok_pkg::CH_CR, 1'b0);
            push_text(csvtok_pkg::CH_LF, 1'b0);
        end
        else if (r < 95)
            push_eod();
        else
        begin
            push_text(delim_reg, 1'b0);
            push_eod();
        end
    endfunction

    function automatic void gen_random(int target, int ws_max);
        int start;
        start = n_text;
        while (n_text - start < target)
            gen_row(ws_max);
    endfunction

    // Mostly no gap; some short gaps, a few long ones, and calm stretches.
    function automatic int pick_gap(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 2)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at %0t, result %0d: %s got 0x%0h want 0x%0h",
                     $realtime, results_seen, what, got, want);
    endtask

    task automatic check_token();
        token_t want;
        results_seen++;
        if (token_q.size() == 0)
        begin
            report_mismatch("result beat with nothing expected", m_tdata, 0);
            return;
        end
        want = token_q.pop_front();
        if (m_tuser[0] !== want.has_byte)
            report_mismatch("has_byte", m_tuser[0], want.has_byte);
        if (m_tdata[7:0] !== want.value)
            report_mismatch("byte_value", m_tdata[7:0], want.value);
        if (m_tuser[1] !== want.fe)
            report_mismatch("field_end", m_tuser[1], want.fe);
        if (m_tuser[2] !== want.re)
            report_mismatch("row_end", m_tuser[2], want.re);
        if (m_tdata[17:8] !== want.col)
            report_mismatch("column", m_tdata[17:8], want.col);
        if (m_tdata[18] !== want.ovf)
            report_mismatch("trim_overflow", m_tdata[18], want.ovf);
        if (m_tlast !== want.is_last)
            report_mismatch("tlast", m_tlast, want.is_last);
    endtask

    // ------------------------------------------------------------------
    // Driver: feed text beats from text_q, predict on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                tokenize_byte(text_t'({s_tdata, s_tuser}));
                beats_in++;
            end
            // hold the beat until taken, then advance
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    drv_item = text_q.pop_front();
                    s_tdata  <= drv_item.data;
                    s_tuser  <= drv_item.eod;
                    s_tvalid <= 1'b1;
                    src_gap  = pick_gap(src_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off once armed; the sender keeps offering meanwhile.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: take result beats with random stalls, check each one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_token();
            if (hold_left != 0)
                m_tready <= 1'b0;
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                snk_gap = pick_gap(snk_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, token_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Pause the sender until every owed token has come back, then let the block settle.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (text_q.size() != 0 || s_tvalid || token_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the delimiter only while the block is idle.
    task automatic write_delim(logic [BYTE_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        delim_reg = v;
        n_settings++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed text, reset delimiter (comma):
        // trimming and inner blanks, doubled quote, LF row end
        push_str(" a b ,\"x\"\"y\"\n");
        // quoted delimiter and LF, junk after close quote, CR LF
        push_str("\",\n\"j\r\n");
        // empty line on a bare CR
        push_str("\r");
        // byte extremes, tab trimmed, end of data after a delimiter
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_str("\t,");
        push_eod();
        // end of data with no open row
        push_eod();
        // end of data inside an unterminated quoted field
        push_str("\"k");
        push_eod();
        wait_drained();

        gen_random(90, 12);
        hold_arm = 1'b1;
        wait_drained();

        write_delim(8'h00);
        gen_random(30, 12);
        wait_drained();
        write_delim(8'hFF);
        gen_random(30, 12);
        wait_drained();
        write_delim(csvtok_pkg::CH_QUOTE);
        gen_random(25, 12);
        wait_drained();
        write_delim(csvtok_pkg::CH_LF);
        gen_random(25, 12);
        wait_drained();
        write_delim(csvtok_pkg::CH_TAB);
        gen_random(25, 12);
        wait_drained();
        write_delim(csvtok_pkg::CH_SP);
        gen_random(20, 12);
        wait_drained();
        write_delim(csvtok_pkg::CH_CR);
        gen_random(20, 12);
        wait_drained();

        // back to comma
        write_delim(csvtok_pkg::DELIM_RESET);
        gen_random(30, 12);
        wait_drained();

        // long blank runs overflow the held-whitespace store (sticky from here)
        gen_random(40, PEND + 4);
        wait_drained();

        if (token_q.size() != 0)
            report_mismatch("results never seen", token_q.size(), 0);
        $display("summary: %0d text beats in, %0d result beats checked, %0d delimiter settings",
                 beats_in, results_seen, n_settings + 1);
        $display("summary: quoting, trimming, CR/LF/CRLF rows, end-of-data flush, %s",
                 "odd delimiters, long output stall, blank overflow");
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/csvtok_pkg.sv
hdl/csvtok_ctrl.sv
hdl/csvtok_dp.sv
hdl/csv_field_tokenizer.sv
sim/tb.sv
